// ===== sv/sorted_table_binary_search_assert.svh =====
// Assertion macros for the sorted table search block.
// Included by the checker module; depends on nothing else.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define STS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define STS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sts_pkg.sv =====
// Shared types and constants for the sorted table search block.
// Used by the controller, the datapath, the top level and the checker.
package sts_pkg;

  // Field widths of the command word and result word
  localparam int CMD_W       = 1;
  localparam int IDX_FIELD_W = 10;
  localparam int VAL_W       = 64;
  localparam int LEN_W       = 11;
  localparam int RES_W       = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // Register map: register index is paddr[2]
  localparam int ADDR_W = 3;
  localparam logic CFG_IDX_TABLE_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_PROBE,
    ST_DONE
  } sts_state_t;

  // Controller to datapath
  typedef struct packed {
    logic write;
    logic init;
    logic prime;
    logic probe;
  } sts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_empty;
    logic probe_done;
  } sts_status_t;

endpackage

// ===== sv/sts_ctrl.sv =====
// Controller state machine for the sorted table search block.
// Depends on sts_pkg; drives the datapath through sts_cmd_t.
module sts_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sts_pkg::CMD_W-1:0] command,
  input  sts_pkg::sts_status_t      status,
  output sts_pkg::sts_cmd_t         cmd,
  output logic                      busy,
  output logic                      done
);
  import sts_pkg::*;

  sts_state_t state, state_next;
  logic       accept;

  assign accept = start && (state == ST_IDLE);

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == CMD_SEARCH) state_next = ST_PRIME;
      end
      ST_PRIME: begin
        state_next = status.range_empty ? ST_DONE : ST_PROBE;
      end
      ST_PROBE: begin
        if (status.probe_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.write = accept && (command == CMD_LOAD);
        cmd.init  = accept && (command == CMD_SEARCH);
      end
      ST_PRIME: cmd.prime = 1'b1;
      ST_PROBE: cmd.probe = 1'b1;
      ST_DONE:  done = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule

// ===== sv/sts_datapath.sv =====
// Datapath of the sorted table search: table memory, bounds, compare.
// Depends on sts_pkg; commanded by sts_ctrl.
module sts_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  sts_pkg::sts_cmd_t               cmd,
  input  logic [sts_pkg::LEN_W-1:0]       table_length,
  input  logic [sts_pkg::IDX_FIELD_W-1:0] entry_index,
  input  logic [sts_pkg::VAL_W-1:0]       entry_value,
  input  logic [sts_pkg::VAL_W-1:0]       search_key,
  output sts_pkg::sts_status_t            status,
  output logic [sts_pkg::RES_W-1:0]       found_index
);
  import sts_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [VAL_W-1:0]        mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic signed [VAL_W-1:0] key;
  logic [CNT_W-1:0]        left, right, left_next, right_next;
  logic [CNT_W-1:0]        len_sat, result;
  logic [CNT_W:0]          sum;
  logic [IDX_W-1:0]        mid, rd_addr;
  logic                    hit, wr_en, rd_en;

  // Clamp the length to the table depth
  assign len_sat = (32'(table_length) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(table_length);

  // Narrow the bounds from the probe just read
  always_comb begin
    left_next  = left;
    right_next = right;
    hit        = 1'b0;
    if (cmd.probe) begin
      if (rd_data > key) begin
        right_next = CNT_W'(mid);
      end else if (rd_data < key) begin
        left_next = CNT_W'(mid) + CNT_W'(1);
      end else begin
        hit = 1'b1;
      end
    end
  end

  // Midpoint of the new range is the next probe address
  assign sum     = {1'b0, left_next} + {1'b0, right_next};
  assign rd_addr = sum[IDX_W:1];

  assign status.range_empty = (left >= right);
  assign status.probe_done  = hit || (left_next >= right_next);

  assign rd_en = (cmd.prime && !status.range_empty) || (cmd.probe && !status.probe_done);
  assign wr_en = cmd.write && (32'(entry_index) < TABLE_DEPTH);

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[IDX_W'(entry_index)] <= entry_value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Hold the key and bounds for the running search
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      key   <= search_key;
      left  <= '0;
      right <= len_sat;
    end else if (cmd.prime || cmd.probe) begin
      left   <= left_next;
      right  <= right_next;
      mid    <= rd_addr;
      result <= hit ? CNT_W'(mid) : right_next;
    end
  end

  assign found_index = RES_W'(result);

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Sorted timestamp table with lower-bound binary search.
// A word with command LOAD writes one 64-bit entry without leaving idle and gives no
// result; a word with command SEARCH bisects entries [0, table_length) and pulses done
// for one cycle with found_index (the matching index, or the first index whose entry
// exceeds the key). A search holds busy up to and including its done cycle and makes at
// most ceil(log2(length+1)) probes (11 for 1024 entries): one probe per cycle, set by the
// single registered read port of the table memory feeding the 64-bit compare. The result
// cannot be stalled: capture it in the cycle done is high. Entries must be loaded before
// a search reaches them. Write table_length via the APB port only while idle (unchecked).
// Depends on sts_pkg, sts_ctrl and sts_datapath.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  // Command port
  input  logic                            start,
  output logic                            busy,
  input  logic [sts_pkg::CMD_W-1:0]       command,
  input  logic [sts_pkg::IDX_FIELD_W-1:0] entry_index,
  input  logic [sts_pkg::VAL_W-1:0]       entry_value,
  input  logic [sts_pkg::VAL_W-1:0]       search_key,
  // Result port
  output logic                            done,
  output logic [sts_pkg::RES_W-1:0]       found_index,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sts_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sts_pkg::*;

  logic [LEN_W-1:0] table_length;
  sts_cmd_t         cmd;
  sts_status_t      status;

  assign pready = 1'b1;

  // Write the length register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == CFG_IDX_TABLE_LENGTH) begin
      table_length <= pwdata[LEN_W-1:0];
    end
  end

  // Read back the length register
  assign prdata = (paddr[2] == CFG_IDX_TABLE_LENGTH) ? 32'(table_length) : '0;

  sts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  sts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .table_length (table_length),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_key   (search_key),
    .status       (status),
    .found_index  (found_index)
  );

endmodule

// ===== sv/sts_checker.sv =====
// Port-level checker for the sorted table search block, bound to the top level.
// Depends on sts_pkg and sorted_table_binary_search_assert.svh.
`include "sorted_table_binary_search_assert.svh"

module sts_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [sts_pkg::CMD_W-1:0] command,
  input logic                      done
);
  import sts_pkg::*;

  // A search word keeps the block busy afterwards
  `STS_ASSERT_NEXT(a_search_busy, clk, rst, start && !busy && command == CMD_SEARCH, busy, "search word did not raise busy")
  // A load word finishes at once and gives no result
  `STS_ASSERT_NEXT(a_load_quiet, clk, rst, start && !busy && command == CMD_LOAD, !busy && !done, "load word held busy or gave a result")
  // A result only ends a busy period
  `STS_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "result strobe while idle")
  // The result strobe lasts one cycle and frees the block
  `STS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "result strobe not a single pulse")

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .done    (done)
);
